// ----- rtl/core/aop_pkg.sv -----
package aop_pkg;

    // CORDIC gain compensation, Q30.
    localparam logic [32:0] CORDIC_GAIN = 33'd652032874;

    // Angle constants, Q2.30 radians.
    localparam logic signed [39:0] ANG_PI      = 40'sd3373259426;
    localparam logic signed [39:0] ANG_TWO_PI  = 40'sd6746518852;
    localparam logic signed [39:0] ANG_HALF_PI = 40'sd1686629713;
    // Bias that lifts any reachable angle above zero before reduction.
    localparam logic signed [39:0] ANG_BIAS    = ANG_PI + (ANG_TWO_PI <<< 5);

    // Opcodes carried in tuser.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Register byte addresses on the APB port.
    localparam logic [2:0] ADDR_VOFF = 3'd0;
    localparam logic [2:0] ADDR_HOFF = 3'd4;

    // Arctangent of 2^-i in Q2.30 radians.
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h3243F6A8;
                5'd1:  v = 32'h1DAC6705;
                5'd2:  v = 32'h0FADBAFC;
                5'd3:  v = 32'h07F56EA6;
                5'd4:  v = 32'h03FEAB76;
                5'd5:  v = 32'h01FFD55B;
                5'd6:  v = 32'h00FFFAAA;
                5'd7:  v = 32'h007FFF55;
                5'd8:  v = 32'h003FFFEA;
                5'd9:  v = 32'h001FFFFD;
                5'd10: v = 32'h000FFFFF;
                5'd11: v = 32'h0007FFFF;
                5'd12: v = 32'h0003FFFF;
                5'd13: v = 32'h0001FFFF;
                5'd14: v = 32'h0000FFFF;
                5'd15: v = 32'h00007FFF;
                5'd16: v = 32'h00003FFF;
                5'd17: v = 32'h00001FFF;
                5'd18: v = 32'h00000FFF;
                5'd19: v = 32'h000007FF;
                5'd20: v = 32'h000003FF;
                5'd21: v = 32'h000001FF;
                5'd22: v = 32'h000000FF;
                5'd23: v = 32'h0000007F;
                5'd24: v = 32'h0000003F;
                5'd25: v = 32'h0000001F;
                5'd26: v = 32'h0000000F;
                5'd27: v = 32'h00000008;
                5'd28: v = 32'h00000004;
                5'd29: v = 32'h00000002;
                5'd30: v = 32'h00000001;
                default: v = 32'h00000000;
            endcase
            atan_q30 = $signed({2'b00, v});
        end
    endfunction

endpackage

// ----- rtl/core/aop_div.sv -----
module aop_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [39:0] i_den,
    output logic               o_done,
    output logic [31:0]        o_quo
);

    logic [63:0] r_n;
    logic [39:0] r_d;
    logic [40:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_neg;
    logic        r_done;

    logic [40:0] rem_sh;
    logic        fits;
    logic [63:0] num_mag;
    logic [39:0] den_mag;

    assign num_mag = i_num[63] ? (~i_num + 64'd1) : i_num;
    assign den_mag = i_den[39] ? (~i_den + 40'd1) : i_den;
    assign rem_sh  = {r_rem[39:0], r_n[63]};
    assign fits    = (rem_sh >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= num_mag;
            r_d   <= den_mag;
            r_rem <= '0;
            r_neg <= i_num[63] ^ i_den[39];
        end else if (r_busy) begin
            r_rem <= fits ? (rem_sh - {1'b0, r_d}) : rem_sh;
            r_n   <= {r_n[62:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (~r_n[31:0] + 32'd1) : r_n[31:0];

endmodule

// ----- rtl/core/arc_odometry_pose_update.sv -----
// Tracking-wheel arc odometry. Each input word is either a sensor sample
// (tuser = 0: cumulative vertical and horizontal wheel distances in Q16.16
// and absolute heading in Q8.24 radians) or a pose load (tuser = 1: new x,
// y and theta), and each produces exactly one output word with the pose.
// A sample with no heading change costs one CORDIC rotation. A sample with
// a heading change costs two CORDIC rotations plus two 64-step bit-serial
// divisions. The input is not ready while a word is being worked on. The
// wheel offsets are to be written over the APB port at byte addresses 0
// (vertical) and 4 (horizontal) only while the block is idle; the block
// itself does not enforce this.
module arc_odometry_pose_update #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: vertical_distance[31:0], horizontal_distance[63:32],
    // heading_angle[95:64].
    input  logic [95:0] i_s_tdata,
    // tuser: opcode.
    input  logic        i_s_tuser,
    // Output stream.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: pose_x[31:0], pose_y[63:32], pose_theta[95:64].
    output logic [95:0] o_m_tdata
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_STEPS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GX   = 4'd1;
    localparam logic [3:0] S_GY   = 4'd2;
    localparam logic [3:0] S_RED  = 4'd3;
    localparam logic [3:0] S_FOLD = 4'd4;
    localparam logic [3:0] S_ITER = 4'd5;
    localparam logic [3:0] S_POST = 4'd6;
    localparam logic [3:0] S_OFF  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // Configuration registers.
    logic [21:0] r_voff;
    logic [21:0] r_hoff;

    // Sequencer and odometry state.
    logic [3:0]  r_state;
    logic        r_phase;  // 0: sine rotation, 1: pose rotation
    logic        r_sel;    // 0: horizontal chord, 1: vertical chord
    logic [2:0]  r_k;
    logic [IW-1:0] r_it;
    logic        r_have_prev;
    logic [31:0] r_last_v;
    logic [31:0] r_last_h;
    logic [31:0] r_last_th;
    logic [31:0] r_pos_x;
    logic [31:0] r_pos_y;
    logic [31:0] r_pos_th;

    // Working registers.
    logic signed [49:0] r_cx;
    logic signed [49:0] r_cy;
    logic signed [39:0] r_v;
    logic signed [33:0] r_a;
    logic signed [39:0] r_avg;
    logic [31:0] r_dv;
    logic [31:0] r_dh;
    logic [31:0] r_dth;
    logic signed [32:0] r_s;
    logic [31:0] r_t2;
    logic [31:0] r_lx;

    logic        r_out_valid;
    logic [95:0] r_out_data;

    // Input unpacking and deltas.
    logic [31:0] in_v;
    logic [31:0] in_h;
    logic [31:0] in_th;
    logic [31:0] d_v;
    logic [31:0] d_h;
    logic [31:0] d_th;
    logic [31:0] prev_th;
    logic signed [39:0] avg_in;
    logic        accept;

    assign in_v    = i_s_tdata[31:0];
    assign in_h    = i_s_tdata[63:32];
    assign in_th   = i_s_tdata[95:64];
    assign d_v     = r_have_prev ? (in_v - r_last_v) : 32'd0;
    assign d_h     = r_have_prev ? (in_h - r_last_h) : 32'd0;
    assign d_th    = r_have_prev ? (in_th - r_last_th) : 32'd0;
    assign prev_th = r_have_prev ? r_last_th : in_th;
    assign avg_in  = $signed({{2{prev_th[31]}}, prev_th, 6'b0})
                   + $signed({{3{d_th[31]}}, d_th, 5'b0});
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // The shared multiplier.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;

    always_comb begin
        mul_a = r_s;
        mul_b = '0;
        case (r_state)
            S_GX: begin
                mul_a = r_cx[32:0];
                mul_b = $signed(aop_pkg::CORDIC_GAIN);
            end
            S_GY: begin
                mul_a = r_cy[32:0];
                mul_b = $signed(aop_pkg::CORDIC_GAIN);
            end
            S_OFF: begin
                mul_b = r_sel ? $signed({{11{r_voff[21]}}, r_voff})
                              : $signed({{11{r_hoff[21]}}, r_hoff});
            end
            S_MUL: begin
                mul_b = r_sel ? $signed({r_dv[31], r_dv}) : $signed({r_dh[31], r_dh});
            end
            default: begin
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Angle reduction, folding and CORDIC micro-rotation.
    logic signed [39:0] red_step;
    logic signed [39:0] fold_a;
    logic signed [49:0] sh_x;
    logic signed [49:0] sh_y;
    logic signed [33:0] atan_v;

    assign red_step = aop_pkg::ANG_TWO_PI <<< r_k;
    assign fold_a   = r_v - aop_pkg::ANG_PI;
    assign sh_x     = r_cx >>> r_it;
    assign sh_y     = r_cy >>> r_it;
    assign atan_v   = aop_pkg::atan_q30(5'(r_it));

    // Chord divider.
    logic        div_start;
    logic        div_done;
    logic [31:0] div_quo;
    logic [31:0] chord_sum;

    assign div_start = (r_state == S_MUL);
    // The chord wraps to 32 bits: quotient term plus offset term.
    assign chord_sum = div_quo + r_t2;

    aop_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod[63:0]),
        .i_den   ($signed({{2{r_dth[31]}}, r_dth, 6'b0})),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Configuration port.
    assign pready = 1'b1;

    always_comb begin
        case (paddr)
            aop_pkg::ADDR_VOFF: prdata = {{10{r_voff[21]}}, r_voff};
            aop_pkg::ADDR_HOFF: prdata = {{10{r_hoff[21]}}, r_hoff};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voff <= '0;
            r_hoff <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr == aop_pkg::ADDR_VOFF) begin
                r_voff <= pwdata[21:0];
            end else if (paddr == aop_pkg::ADDR_HOFF) begin
                r_hoff <= pwdata[21:0];
            end
        end
    end

    // Control and pose state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_sel       <= 1'b0;
            r_k         <= '0;
            r_it        <= '0;
            r_have_prev <= 1'b0;
            r_last_v    <= '0;
            r_last_h    <= '0;
            r_last_th   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_th    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new word in S_OUT takes over the output register itself.
            if (r_out_valid && i_m_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_s_tuser == aop_pkg::OP_LOAD) begin
                            r_pos_x  <= in_v;
                            r_pos_y  <= in_h;
                            r_pos_th <= in_th;
                            r_state  <= S_OUT;
                        end else begin
                            r_last_v    <= in_v;
                            r_last_h    <= in_h;
                            r_last_th   <= in_th;
                            r_have_prev <= 1'b1;
                            r_phase     <= (d_th == 32'd0);
                            r_sel       <= 1'b0;
                            r_state     <= S_GX;
                        end
                    end
                end
                S_GX: begin
                    r_state <= S_GY;
                end
                S_GY: begin
                    r_k     <= 3'd5;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_k <= r_k - 3'd1;
                    if (r_k == 3'd0) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_it    <= '0;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    r_it <= r_it + 1'b1;
                    if (r_it == LAST_IT) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_phase) begin
                        r_pos_x  <= r_pos_x + r_cx[47:16];
                        r_pos_y  <= r_pos_y + r_cy[47:16];
                        r_pos_th <= r_pos_th + r_dth;
                        r_state  <= S_OUT;
                    end else begin
                        r_sel   <= 1'b0;
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_sel) begin
                            r_phase <= 1'b1;
                            r_state <= S_GX;
                        end else begin
                            r_sel   <= 1'b1;
                            r_state <= S_OFF;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept && (i_s_tuser == aop_pkg::OP_SAMPLE)) begin
                    r_dv  <= d_v;
                    r_dh  <= d_h;
                    r_dth <= d_th;
                    r_avg <= avg_in;
                    if (d_th == 32'd0) begin
                        // Straight-line move: rotate the wheel deltas directly.
                        r_cx <= $signed({{18{d_h[31]}}, d_h});
                        r_cy <= $signed({{18{d_v[31]}}, d_v});
                        r_v  <= aop_pkg::ANG_BIAS - avg_in;
                    end else begin
                        r_cx <= 50'sd1073741824;
                        r_cy <= '0;
                        r_v  <= aop_pkg::ANG_BIAS + $signed({{3{d_th[31]}}, d_th, 5'b0});
                    end
                end
            end
            S_GX: begin
                r_cx <= prod[63:14];
            end
            S_GY: begin
                r_cy <= prod[63:14];
            end
            S_RED: begin
                if (r_v >= red_step) begin
                    r_v <= r_v - red_step;
                end
            end
            S_FOLD: begin
                if (fold_a > aop_pkg::ANG_HALF_PI) begin
                    r_cx <= -r_cx;
                    r_cy <= -r_cy;
                    r_a  <= 34'(fold_a - aop_pkg::ANG_PI);
                end else if (fold_a < -aop_pkg::ANG_HALF_PI) begin
                    r_cx <= -r_cx;
                    r_cy <= -r_cy;
                    r_a  <= 34'(fold_a + aop_pkg::ANG_PI);
                end else begin
                    r_a <= 34'(fold_a);
                end
            end
            S_ITER: begin
                if (!r_a[33]) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_a  <= r_a - atan_v;
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_a  <= r_a + atan_v;
                end
            end
            S_POST: begin
                if (!r_phase) begin
                    r_s <= $signed({r_cy[47:16], 1'b0});
                end
            end
            S_OFF: begin
                r_t2 <= prod[61:30];
            end
            S_DIV: begin
                if (div_done) begin
                    if (r_sel) begin
                        // Both chords done: load the pose rotation.
                        r_cx <= $signed({{18{r_lx[31]}}, r_lx});
                        r_cy <= $signed({{18{chord_sum[31]}}, chord_sum});
                        r_v  <= aop_pkg::ANG_BIAS - r_avg;
                    end else begin
                        r_lx <= chord_sum;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    r_out_data <= {r_pos_th, r_pos_y, r_pos_x};
                end
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
